/* hw/rtl/tpps_pkg.sv */
// Shared constants and types for the timer prescaler and period search block.
package tpps_pkg;

  // Width of the timer's prescaler and reload counters.
  localparam int COUNTER_BITS = 16;

  localparam int DATA_W  = 32;
  localparam int FIELD_W = 16;
  localparam int CNT_W   = $clog2(DATA_W);

  // Last prescaler value; reaching it ends the search as not found.
  localparam logic [COUNTER_BITS-1:0] P_LAST = {COUNTER_BITS{1'b1}};
  // A quotient above this gives a reload value past the counter range.
  localparam logic [DATA_W:0] QUOT_MAX = (DATA_W + 1)'(1) << COUNTER_BITS;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

  typedef struct packed {
    logic              done;
    logic              rem_zero;
    logic [DATA_W-1:0] quot;
  } div_res_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_DIV   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

endpackage

/* hw/rtl/timer_prescale_period_search_top.sv */
// Timer prescaler and reload period search: top level with sequencer and result register.
// Given a target update frequency, the block tries prescalers p = 1, 2, ... and for each
// one divides the core clock (written on the cfg port, 72000000 after reset) by
// (p+1)*target_hz, stopping at the first exact division whose reload value (quotient - 1)
// fits the counter. It returns found, prescale and period, or all zeros when no pair
// exists or target_hz is zero. One item is searched at a time: each tried prescaler takes
// one range check and then a bit-serial division. The search stops early once
// (p+1)*target_hz exceeds the core clock. A new item is taken while the previous result
// still waits on the output.
module timer_prescale_period_search_top
  import tpps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [DATA_W-1:0]  core_clock,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [DATA_W-1:0]  target_hz,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               found,
  output logic [FIELD_W-1:0] prescale,
  output logic [FIELD_W-1:0] period
);

  state_t                  state, state_next;
  logic [DATA_W-1:0]       clk_hz;
  logic [DATA_W-1:0]       hz, hz_next;
  logic [DATA_W:0]         div_val, div_val_next;
  logic [COUNTER_BITS-1:0] p, p_next;
  logic                    res_found, res_found_next;
  logic [FIELD_W-1:0]      res_pres, res_pres_next;
  logic [FIELD_W-1:0]      res_per, res_per_next;
  logic                    div_start;
  logic                    load_out;
  div_res_t                dres;
  logic [DATA_W-1:0]       p_wide;
  logic [DATA_W-1:0]       quot_m1;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign p_wide    = DATA_W'(p);
  assign quot_m1   = dres.quot - DATA_W'(1);

  tpps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (clk_hz),
    .divisor  (div_val[DATA_W-1:0]),
    .res      (dres)
  );

  always_comb begin
    state_next     = state;
    hz_next        = hz;
    div_val_next   = div_val;
    p_next         = p;
    res_found_next = res_found;
    res_pres_next  = res_pres;
    res_per_next   = res_per;
    div_start      = 1'b0;
    load_out       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          hz_next        = target_hz;
          div_val_next   = {target_hz, 1'b0};
          p_next         = COUNTER_BITS'(1);
          res_found_next = 1'b0;
          res_pres_next  = '0;
          res_per_next   = '0;
          state_next     = (target_hz == '0) ? S_DONE : S_CHECK;
        end
      end
      S_CHECK: begin
        // divisor above the clock means quotient zero: nothing larger can work
        if (p == P_LAST || div_val > {1'b0, clk_hz}) begin
          state_next = S_DONE;
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (dres.done) begin
          if (dres.rem_zero && {1'b0, dres.quot} <= QUOT_MAX) begin
            res_found_next = 1'b1;
            res_pres_next  = p_wide[FIELD_W-1:0];
            res_per_next   = quot_m1[FIELD_W-1:0];
            state_next     = S_DONE;
          end else begin
            p_next       = p + COUNTER_BITS'(1);
            div_val_next = div_val + {1'b0, hz};
            state_next   = S_CHECK;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      clk_hz    <= DATA_W'(72000000);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        clk_hz <= core_clock;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hz        <= hz_next;
    div_val   <= div_val_next;
    p         <= p_next;
    res_found <= res_found_next;
    res_pres  <= res_pres_next;
    res_per   <= res_per_next;
    if (load_out) begin
      found    <= res_found;
      prescale <= res_pres;
      period   <= res_per;
    end
  end

  a_div_in_range: assert property (@(posedge clk) disable iff (rst)
      state == S_DIV |-> div_val <= {1'b0, clk_hz})
    else $error("division running with divisor above core clock");
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
      dres.done |-> state == S_DIV)
    else $error("divider result outside of divide state");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
      out_valid && !found |-> prescale == '0 && period == '0)
    else $error("not-found result carries nonzero fields");

endmodule

/* hw/rtl/tpps_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module tpps_div
  import tpps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output div_res_t          res
);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] dvd_sr;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quot;

  logic [DATA_W:0]   trial;
  logic              ge;
  logic [DATA_W:0]   diff;

  assign trial = {rem, dvd_sr[DATA_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_sr <= dividend;
      dvs    <= divisor;
      rem    <= '0;
      quot   <= '0;
    end else if (busy) begin
      dvd_sr <= {dvd_sr[DATA_W-2:0], 1'b0};
      // remainder stays below the divisor, so the top bit drops
      rem    <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quot   <= {quot[DATA_W-2:0], ge};
    end
  end

  assign res.done     = done;
  assign res.rem_zero = (rem == '0);
  assign res.quot     = quot;

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");

endmodule
